>>> sv/lrct_pkg.sv
package lrct_pkg;

  localparam int ENTRIES_DEF      = 16;
  localparam int FILE_ID_BITS_DEF = 16;

  localparam int OFFSET_W = 64;
  localparam int LEN_W    = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int MAXE_W   = 5;
  localparam int LIM_W    = 8;

  // request commands
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // answer codes
  localparam logic [1:0] STS_REFUSED = 2'd0;
  localparam logic [1:0] STS_MISS    = 2'd1;
  localparam logic [1:0] STS_HIT     = 2'd2;
  localparam logic [1:0] STS_DONE    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'd1;

  // operations broadcast to the row of cells
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_CLEAR  = 3'd1;
  localparam logic [2:0] OP_TOUCH  = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_EVICT  = 3'd4;
  localparam logic [2:0] OP_PLACE  = 3'd5;

  typedef struct packed {
    logic [2:0]          op;
    logic [OFFSET_W-1:0] offset;
    logic [LEN_W-1:0]    length;
  } cell_ctl_t;

endpackage

>>> sv/lru_read_cache_table_top.sv
// channel   direction  ports                                              handshake
// request   in         in_cmd in_has_position in_file_id in_offset        in_valid / in_stall
//                      in_length
// result    out        out_status out_slot out_byte_count out_evicted     out_valid / out_stall
// config    in         cfg_index cfg_wdata                                cfg_we
//
// one request at a time. the sequencer steps the cell row: search, then rank update on a
// hit, or for an insert removal of an existing key, eviction and placement; each step is
// one broadcast to the cells. the result register then waits while out_stall is high.
// synchronous reset empties the table at once; no sweep is needed.
// in_stall is high whenever a request is in progress.
module lru_read_cache_table_top import lrct_pkg::*; #(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int FILE_ID_BITS = FILE_ID_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_cmd,
  input  logic                    in_has_position,
  input  logic [FILE_ID_BITS-1:0] in_file_id,
  input  logic [OFFSET_W-1:0]     in_offset,
  input  logic [LEN_W-1:0]        in_length,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic [3:0]              out_slot,
  output logic [LEN_W-1:0]        out_byte_count,
  output logic                    out_evicted
);

  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = SLOT_W;
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FIND   = 3'd1;
  localparam logic [2:0] ST_TOUCH  = 3'd2;
  localparam logic [2:0] ST_REMOVE = 3'd3;
  localparam logic [2:0] ST_EVICT  = 3'd4;
  localparam logic [2:0] ST_PLACE  = 3'd5;
  localparam logic [2:0] ST_CLEAR  = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CFG_W-1:0]        min_size_r;
  logic [MAXE_W-1:0]       max_ent_r;
  logic [FILE_ID_BITS-1:0] req_file_r, req_file_nxt;
  logic [OFFSET_W-1:0]     req_offset_r, req_offset_nxt;
  logic [LEN_W-1:0]        req_len_r, req_len_nxt;
  logic [1:0]              req_cmd_r, req_cmd_nxt;
  logic [RANK_W-1:0]       hit_rank_r, hit_rank_nxt;
  logic [1:0]              res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]       res_slot_r, res_slot_nxt;
  logic [LEN_W-1:0]        res_bytes_r, res_bytes_nxt;
  logic                    res_ev_r, res_ev_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              out_status_r;
  logic [3:0]              out_slot_r;
  logic [LEN_W-1:0]        out_bytes_r;
  logic                    out_ev_r;

  cell_ctl_t               cell_ctl;
  logic [RANK_W-1:0]       ref_rank;
  logic [ENTRIES:0]        taken;
  logic [ENTRIES-1:0]      cell_match;
  logic [ENTRIES-1:0]      cell_claim;
  logic [RANK_W-1:0]       cell_rank [ENTRIES];
  logic [LEN_W-1:0]        cell_len  [ENTRIES];

  logic                    hit_any;
  logic [SLOT_W-1:0]       hit_slot;
  logic [RANK_W-1:0]       hit_rank;
  logic [LEN_W-1:0]        hit_len;
  logic [SLOT_W-1:0]       free_slot;
  logic [LIM_W-1:0]        limit;
  logic [LIM_W-1:0]        max_ext;
  logic                    accept;
  logic                    load_out;
  logic [SLOT_W+3:0]       slot_ext;

  assign taken[0] = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lrct_cell #(
      .FILE_W (FILE_ID_BITS),
      .RANK_W (RANK_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .key_file  (req_file_r),
      .ref_rank  (ref_rank),
      .taken_in  (taken[g]),
      .taken_out (taken[g+1]),
      .match     (cell_match[g]),
      .claim     (cell_claim[g]),
      .rank      (cell_rank[g]),
      .length    (cell_len[g])
    );
  end

  // at most one valid cell holds a given key, so plain or-reductions pick it
  always_comb begin
    hit_any   = |cell_match;
    hit_slot  = '0;
    hit_rank  = '0;
    hit_len   = '0;
    free_slot = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cell_match[i]) begin
        hit_slot = hit_slot | SLOT_W'(i);
        hit_rank = hit_rank | cell_rank[i];
        hit_len  = hit_len | cell_len[i];
      end
      if (cell_claim[i]) begin
        free_slot = free_slot | SLOT_W'(i);
      end
    end
  end

  always_comb begin
    max_ext = LIM_W'(max_ent_r);
    if (max_ext == '0) begin
      limit = LIM_W'(1);
    end else if (max_ext > LIM_W'(ENTRIES)) begin
      limit = LIM_W'(ENTRIES);
    end else begin
      limit = max_ext;
    end
  end

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    cell_ctl.offset = req_offset_r;
    cell_ctl.length = req_len_r;
    cell_ctl.op     = OP_NONE;
    ref_rank        = hit_rank_r;
    case (state_r)
      ST_CLEAR:  cell_ctl.op = OP_CLEAR;
      ST_TOUCH:  cell_ctl.op = OP_TOUCH;
      ST_REMOVE: cell_ctl.op = OP_REMOVE;
      ST_EVICT: begin
        if (count_r != '0 && LIM_W'(count_r) >= limit) begin
          cell_ctl.op = OP_EVICT;
        end
        ref_rank = RANK_W'(count_r - CNT_W'(1));
      end
      ST_PLACE:  cell_ctl.op = OP_PLACE;
      default:   cell_ctl.op = OP_NONE;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    req_cmd_nxt    = req_cmd_r;
    req_file_nxt   = req_file_r;
    req_offset_nxt = req_offset_r;
    req_len_nxt    = req_len_r;
    hit_rank_nxt   = hit_rank_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_bytes_nxt  = res_bytes_r;
    res_ev_nxt     = res_ev_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_cmd_nxt    = in_cmd;
          req_file_nxt   = in_file_id;
          req_offset_nxt = in_offset;
          req_len_nxt    = in_length;
          res_status_nxt = STS_REFUSED;
          res_slot_nxt   = '0;
          res_bytes_nxt  = '0;
          res_ev_nxt     = 1'b0;
          if (in_cmd == CMD_CLEAR) begin
            state_nxt = ST_CLEAR;
          end else if ((in_cmd == CMD_LOOKUP || in_cmd == CMD_INSERT) &&
                       in_has_position && in_length > min_size_r) begin
            state_nxt = ST_FIND;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_FIND: begin
        hit_rank_nxt = hit_rank;
        if (req_cmd_r == CMD_LOOKUP) begin
          if (hit_any && hit_len >= req_len_r) begin
            res_status_nxt = STS_HIT;
            res_slot_nxt   = hit_slot;
            res_bytes_nxt  = req_len_r;
            state_nxt      = ST_TOUCH;
          end else begin
            res_status_nxt = STS_MISS;
            state_nxt      = ST_DONE;
          end
        end else begin
          state_nxt = hit_any ? ST_REMOVE : ST_EVICT;
        end
      end
      ST_TOUCH: begin
        state_nxt = ST_DONE;
      end
      ST_REMOVE: begin
        count_nxt = count_r - CNT_W'(1);
        state_nxt = ST_EVICT;
      end
      ST_EVICT: begin
        if (cell_ctl.op == OP_EVICT) begin
          count_nxt  = count_r - CNT_W'(1);
          res_ev_nxt = 1'b1;
        end
        state_nxt = ST_PLACE;
      end
      ST_PLACE: begin
        // a free cell always exists here, eviction made room if needed
        count_nxt      = count_r + CNT_W'(1);
        res_slot_nxt   = free_slot;
        res_status_nxt = STS_DONE;
        state_nxt      = ST_DONE;
      end
      ST_CLEAR: begin
        count_nxt      = '0;
        res_status_nxt = STS_DONE;
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign slot_ext = {4'b0000, res_slot_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      min_size_r  <= '0;
      max_ent_r   <= MAXE_W'(16);
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_MIN_SIZE) begin
        min_size_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_MAX_ENTRIES) begin
        max_ent_r <= cfg_wdata[MAXE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    req_cmd_r    <= req_cmd_nxt;
    req_file_r   <= req_file_nxt;
    req_offset_r <= req_offset_nxt;
    req_len_r    <= req_len_nxt;
    hit_rank_r   <= hit_rank_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_bytes_r  <= res_bytes_nxt;
    res_ev_r     <= res_ev_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_slot_r   <= slot_ext[3:0];
      out_bytes_r  <= res_bytes_r;
      out_ev_r     <= res_ev_r;
    end
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot       = out_slot_r;
  assign out_byte_count = out_bytes_r;
  assign out_evicted    = out_ev_r;

endmodule

>>> sv/lrct_cell.sv
module lrct_cell import lrct_pkg::*; #(
  parameter int FILE_W = FILE_ID_BITS_DEF,
  parameter int RANK_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [FILE_W-1:0] key_file,
  input  logic [RANK_W-1:0] ref_rank,
  input  logic              taken_in,
  output logic              taken_out,
  output logic              match,
  output logic              claim,
  output logic [RANK_W-1:0] rank,
  output logic [LEN_W-1:0]  length
);

  logic                valid_r, valid_nxt;
  logic [RANK_W-1:0]   rank_r, rank_nxt;
  logic [FILE_W-1:0]   file_r;
  logic [OFFSET_W-1:0] offset_r;
  logic [LEN_W-1:0]    length_r;

  always_comb begin
    match     = valid_r && (file_r == key_file) && (offset_r == ctl.offset);
    // first free cell along the row takes a new entry
    claim     = !valid_r && !taken_in;
    taken_out = taken_in || !valid_r;
    rank      = rank_r;
    length    = length_r;
  end

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    case (ctl.op)
      OP_CLEAR: begin
        valid_nxt = 1'b0;
      end
      OP_TOUCH: begin
        if (match) begin
          rank_nxt = '0;
        end else if (valid_r && rank_r < ref_rank) begin
          rank_nxt = rank_r + RANK_W'(1);
        end
      end
      OP_REMOVE: begin
        if (match) begin
          valid_nxt = 1'b0;
        end else if (valid_r && rank_r > ref_rank) begin
          rank_nxt = rank_r - RANK_W'(1);
        end
      end
      OP_EVICT: begin
        // the oldest entry holds the top rank, so nobody else moves
        if (valid_r && rank_r == ref_rank) begin
          valid_nxt = 1'b0;
        end
      end
      OP_PLACE: begin
        if (claim) begin
          valid_nxt = 1'b1;
          rank_nxt  = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + RANK_W'(1);
        end
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rank_r <= rank_nxt;
    if (ctl.op == OP_PLACE && claim) begin
      file_r   <= key_file;
      offset_r <= ctl.offset;
      length_r <= ctl.length;
    end
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import lrct_pkg::*;

  localparam int FID_W     = FILE_ID_BITS_DEF;
  localparam int POOL_KEYS = 24;
  localparam int HOLD_LEN  = 300;
  localparam int STUCK_MAX = 3000;

  // the one encoding the block does not define
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]          cmd;
    logic                has_pos;
    logic [FID_W-1:0]    file_id;
    logic [OFFSET_W-1:0] offset;
    logic [LEN_W-1:0]    length;
  } cache_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       slot;
    logic [LEN_W-1:0] byte_count;
    logic             evicted;
  } cache_ans_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_SIZE;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_cmd = CMD_LOOKUP;
  logic                 in_has_position = 1'b0;
  logic [FID_W-1:0]     in_file_id = '0;
  logic [OFFSET_W-1:0]  in_offset = '0;
  logic [LEN_W-1:0]     in_length = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_status;
  logic [3:0]           out_slot;
  logic [LEN_W-1:0]     out_byte_count;
  logic                 out_evicted;

  lru_read_cache_table_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_has_position(in_has_position),
    .in_file_id     (in_file_id),
    .in_offset      (in_offset),
    .in_length      (in_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_byte_count (out_byte_count),
    .out_evicted    (out_evicted)
  );

  always #5 clk = ~clk;

  // predictor copy of the table and its registers
  logic [LEN_W-1:0]    cfg_min_size = '0;
  logic [MAXE_W-1:0]   cfg_max_entries = 5'd16;
  bit                  tbl_valid [ENTRIES_DEF];
  logic [FID_W-1:0]    tbl_file  [ENTRIES_DEF];
  logic [OFFSET_W-1:0] tbl_off   [ENTRIES_DEF];
  logic [LEN_W-1:0]    tbl_len   [ENTRIES_DEF];
  int unsigned         tbl_rank  [ENTRIES_DEF];

  cache_req_t reqs_pending [$];
  cache_ans_t answers_due  [$];
  cache_req_t nxt;

  logic [FID_W-1:0]    pool_file [POOL_KEYS];
  logic [OFFSET_W-1:0] pool_off  [POOL_KEYS];

  int  reqs_issued = 0;
  int  reqs_done = 0;
  int  n_errors = 0;
  int  n_hit = 0, n_miss = 0, n_refused = 0, n_done = 0, n_evict = 0;
  int  idle_pct = 0;
  int  stall_pct = 0;
  int  hold_token = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  quiet_cycles = 0;
  bit  req_taken = 1'b0;

  function automatic int key_slot(logic [FID_W-1:0] f, logic [OFFSET_W-1:0] o);
    for (int i = 0; i < ENTRIES_DEF; i++)
      if (tbl_valid[i] && tbl_file[i] == f && tbl_off[i] == o) return i;
    return -1;
  endfunction

  function automatic void drop_entry(int s);
    int unsigned r;
    r = tbl_rank[s];
    tbl_valid[s] = 1'b0;
    for (int i = 0; i < ENTRIES_DEF; i++)
      if (tbl_valid[i] && tbl_rank[i] > r) tbl_rank[i]--;
  endfunction

  function automatic void promote(int s);
    int unsigned r;
    r = tbl_rank[s];
    for (int i = 0; i < ENTRIES_DEF; i++)
      if (i != s && tbl_valid[i] && tbl_rank[i] < r) tbl_rank[i]++;
    tbl_rank[s] = 0;
  endfunction

  function automatic cache_ans_t lru_answer(cache_req_t r);
    cache_ans_t a;
    int hit_idx, oldest, free_idx, fill, lim;
    a = '{STS_REFUSED, 4'd0, '0, 1'b0};
    if (r.cmd == CMD_CLEAR) begin
      for (int i = 0; i < ENTRIES_DEF; i++) tbl_valid[i] = 1'b0;
      a.status = STS_DONE;
    end else if ((r.cmd == CMD_LOOKUP || r.cmd == CMD_INSERT) && r.has_pos &&
                 r.length > cfg_min_size) begin
      hit_idx = key_slot(r.file_id, r.offset);
      if (r.cmd == CMD_LOOKUP) begin
        // a present but shorter entry is a miss and keeps its rank
        if (hit_idx >= 0 && tbl_len[hit_idx] >= r.length) begin
          promote(hit_idx);
          a.status = STS_HIT;
          a.slot = 4'(hit_idx);
          a.byte_count = r.length;
        end else begin
          a.status = STS_MISS;
        end
      end else begin
        if (hit_idx >= 0) drop_entry(hit_idx);
        fill = 0;
        for (int i = 0; i < ENTRIES_DEF; i++) if (tbl_valid[i]) fill++;
        lim = (cfg_max_entries == 0) ? 1 :
              (cfg_max_entries > ENTRIES_DEF) ? ENTRIES_DEF : int'(cfg_max_entries);
        if (fill > 0 && fill >= lim) begin
          oldest = -1;
          for (int i = 0; i < ENTRIES_DEF; i++)
            if (tbl_valid[i] && (oldest < 0 || tbl_rank[i] > tbl_rank[oldest])) oldest = i;
          drop_entry(oldest);
          a.evicted = 1'b1;
        end
        free_idx = -1;
        for (int i = 0; i < ENTRIES_DEF; i++)
          if (!tbl_valid[i]) begin
            free_idx = i;
            break;
          end
        if (free_idx >= 0) begin
          for (int i = 0; i < ENTRIES_DEF; i++) if (tbl_valid[i]) tbl_rank[i]++;
          tbl_valid[free_idx] = 1'b1;
          tbl_file[free_idx] = r.file_id;
          tbl_off[free_idx] = r.offset;
          tbl_len[free_idx] = r.length;
          tbl_rank[free_idx] = 0;
          a.slot = 4'(free_idx);
        end
        a.status = STS_DONE;
      end
    end
    return a;
  endfunction

  function automatic void field_check(string what, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      n_errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want_v, got_v);
    end
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (reqs_pending.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        nxt = reqs_pending.pop_front();
        in_valid <= 1'b1;
        in_cmd <= nxt.cmd;
        in_has_position <= nxt.has_pos;
        in_file_id <= nxt.file_id;
        in_offset <= nxt.offset;
        in_length <= nxt.length;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor: predict on request accept, compare on result accept
  always @(posedge clk) begin
    cache_req_t seen;
    cache_ans_t want;
    if (rst_n) begin
      req_taken = in_valid && !in_stall;
      if (req_taken) begin
        seen = '{in_cmd, in_has_position, in_file_id, in_offset, in_length};
        answers_due.push_back(lru_answer(seen));
        reqs_done++;
      end
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result: expected none, got status %0d slot %0d bytes %0h ev %0d",
                   $time, out_status, out_slot, out_byte_count, out_evicted);
        end else begin
          want = answers_due.pop_front();
          field_check("status", 64'(want.status), 64'(out_status));
          field_check("slot", 64'(want.slot), 64'(out_slot));
          field_check("byte_count", 64'(want.byte_count), 64'(out_byte_count));
          field_check("evicted", 64'(want.evicted), 64'(out_evicted));
          case (want.status)
            STS_HIT:     n_hit++;
            STS_MISS:    n_miss++;
            STS_REFUSED: n_refused++;
            default:     n_done++;
          endcase
          if (want.evicted) n_evict++;
        end
      end
      if (req_taken || (out_valid && !out_stall) || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STUCK_MAX) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, answers_due.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_MIN_SIZE) cfg_min_size = data;
    else cfg_max_entries = data[MAXE_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (reqs_done != reqs_issued || answers_due.size() != 0) @(negedge clk);
  endtask

  task automatic queue_item(cache_req_t r);
    reqs_pending.push_back(r);
    reqs_issued++;
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return cfg_min_size;
      3:       return cfg_min_size + 1;
      4:       return $urandom();
      default: return cfg_min_size + $urandom_range(1, 300);
    endcase
  endfunction

  task automatic queue_random(int n);
    cache_req_t r;
    int k, pick;
    for (int j = 0; j < n; j++) begin
      pick = $urandom_range(0, 99);
      r.cmd = (pick < 48) ? CMD_LOOKUP : (pick < 94) ? CMD_INSERT :
              (pick < 97) ? CMD_CLEAR : CMD_UNUSED;
      r.has_pos = ($urandom_range(0, 99) < 92);
      k = $urandom_range(0, POOL_KEYS - 1);
      if ($urandom_range(0, 19) == 0) begin
        pool_file[k] = FID_W'($urandom_range(0, 65535));
        pool_off[k] = {$urandom(), $urandom()};
      end
      if ($urandom_range(0, 99) < 15) begin
        r.file_id = FID_W'($urandom_range(0, 65535));
        r.offset = {$urandom(), $urandom()};
      end else begin
        r.file_id = pool_file[k];
        r.offset = pool_off[k];
      end
      r.length = pick_length();
      queue_item(r);
    end
  endtask

  task automatic run_phase(int n, int send_gap, int recv_gap);
    @(posedge clk);
    idle_pct = send_gap;
    stall_pct = recv_gap;
    queue_random(n);
    drain();
  endtask

  localparam logic [FID_W-1:0]    FID_MAX = '1;
  localparam logic [OFFSET_W-1:0] OFF_MAX = '1;

  initial begin
    for (int i = 0; i < POOL_KEYS; i++) begin
      // some neighbours share a file id so only the offset tells them apart
      pool_file[i] = (i % 3 == 2) ? pool_file[i - 1] : 16'($urandom_range(0, 65535));
      pool_off[i] = {$urandom(), $urandom()};
    end
    pool_file[0] = '0;
    pool_off[0] = '0;
    pool_file[1] = FID_MAX;
    pool_off[1] = OFF_MAX;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: default registers, no gaps
    @(posedge clk);
    queue_item('{CMD_LOOKUP, 1'b1, '0, '0, 32'd1});
    queue_item('{CMD_INSERT, 1'b1, FID_MAX, OFF_MAX, 32'd100});
    queue_item('{CMD_LOOKUP, 1'b1, FID_MAX, OFF_MAX, 32'd100});
    queue_item('{CMD_LOOKUP, 1'b1, FID_MAX, OFF_MAX, 32'd101});
    queue_item('{CMD_LOOKUP, 1'b0, FID_MAX, OFF_MAX, 32'd1});
    queue_item('{CMD_LOOKUP, 1'b1, FID_MAX, OFF_MAX, 32'd0});
    queue_item('{CMD_INSERT, 1'b0, 16'h1234, 64'h10, 32'd50});
    queue_item('{CMD_UNUSED, 1'b1, FID_MAX, OFF_MAX, 32'd100});
    queue_item('{CMD_INSERT, 1'b1, FID_MAX, OFF_MAX, 32'd200});
    queue_item('{CMD_INSERT, 1'b1, '0, '0, '1});
    queue_item('{CMD_LOOKUP, 1'b1, '0, '0, '1});
    queue_item('{CMD_LOOKUP, 1'b1, FID_MAX, OFF_MAX, 32'd150});
    queue_item('{CMD_CLEAR, 1'b0, 16'h5a5a, 64'h1, 32'd0});
    queue_item('{CMD_LOOKUP, 1'b1, FID_MAX, OFF_MAX, 32'd1});
    drain();

    // a zero limit behaves as one entry
    write_reg(CFG_MAX_ENTRIES, 32'd0);
    @(posedge clk);
    queue_item('{CMD_INSERT, 1'b1, FID_MAX, OFF_MAX, 32'd10});
    queue_item('{CMD_INSERT, 1'b1, '0, '0, 32'd10});
    queue_item('{CMD_LOOKUP, 1'b1, FID_MAX, OFF_MAX, 32'd10});
    queue_item('{CMD_LOOKUP, 1'b1, '0, '0, 32'd10});
    drain();

    // limit above the table size, minimum just under the top
    write_reg(CFG_MAX_ENTRIES, 32'd31);
    write_reg(CFG_MIN_SIZE, 32'hFFFF_FFFE);
    @(posedge clk);
    queue_item('{CMD_INSERT, 1'b1, 16'h8001, 64'h8000_0000_0000_0001, '1});
    queue_item('{CMD_LOOKUP, 1'b1, 16'h8001, 64'h8000_0000_0000_0001, 32'hFFFF_FFFE});
    queue_item('{CMD_LOOKUP, 1'b1, 16'h8001, 64'h8000_0000_0000_0001, '1});
    drain();
    write_reg(CFG_MIN_SIZE, '1);
    run_phase(10, 0, 0);

    write_reg(CFG_MIN_SIZE, 32'd0);
    write_reg(CFG_MAX_ENTRIES, 32'd16);
    run_phase(60, 0, 0);

    write_reg(CFG_MIN_SIZE, 32'd1000);
    run_phase(30, 52, 0);
    // sender waits here until every result is back
    run_phase(30, 52, 0);

    write_reg(CFG_MIN_SIZE, 32'd0);
    write_reg(CFG_MAX_ENTRIES, 32'd4);
    run_phase(60, 0, 52);

    write_reg(CFG_MIN_SIZE, 32'd7);
    write_reg(CFG_MAX_ENTRIES, 32'd16);
    run_phase(60, 14, 14);
    // limit lowered below the entries the last phase may have left
    write_reg(CFG_MAX_ENTRIES, 32'd3);
    run_phase(40, 14, 14);

    write_reg(CFG_MIN_SIZE, 32'd0);
    write_reg(CFG_MAX_ENTRIES, 32'd31);
    hold_token++;
    run_phase(50, 0, 0);

    write_reg(CFG_MAX_ENTRIES, 32'd1);
    run_phase(50, 52, 0);

    repeat (10) @(posedge clk);
    $display("checked %0d requests: %0d hits, %0d misses, %0d refused, %0d stored or cleared",
             reqs_done, n_hit, n_miss, n_refused, n_done);
    $display("%0d evictions; min_size 0 to all ones, max_entries 0 to 31, gaps, stalls and hold",
             n_evict);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/lrct_pkg.sv
sv/lrct_cell.sv
sv/lru_read_cache_table_top.sv
dv/tb.sv
